[design/egcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types and constants for the extended gcd / diophantine solver.
// ----------------------------------------------------------------------------
package egcd_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    localparam int FIELD_W      = 32;
    localparam int COEF_W       = 33;
    localparam int SOL_W        = 64;
    localparam int IN_TDATA_W   = 3 * FIELD_W;
    localparam int OUT_FIELDS_W = FIELD_W + 2 * COEF_W + 1 + 2 * SOL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int GCD_LSB = 0;
    localparam int BX_LSB  = GCD_LSB + FIELD_W;
    localparam int BY_LSB  = BX_LSB + COEF_W;
    localparam int OK_BIT  = BY_LSB + COEF_W;
    localparam int SX_LSB  = OK_BIT + 1;
    localparam int SY_LSB  = SX_LSB + SOL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPD,
        ST_SOLVE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
    } unit_ctl_t;

endpackage

[design/egcd_divmac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_divmac
// Shared radix-2 restoring divider; quotient bits are folded into two
// multiply-accumulators so q*mul_x and q*mul_y are ready with the remainder.
// ----------------------------------------------------------------------------
module egcd_divmac
    import egcd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  unit_ctl_t                     ctl,
    input  logic [DATA_WIDTH-1:0]         dividend,
    input  logic [DATA_WIDTH-1:0]         divisor,
    input  logic signed [DATA_WIDTH+1:0]  mul_x,
    input  logic signed [DATA_WIDTH+1:0]  mul_y,
    output logic [DATA_WIDTH-1:0]         rem,
    output logic signed [2*DATA_WIDTH-1:0] acc_x,
    output logic signed [2*DATA_WIDTH-1:0] acc_y,
    output logic                          last
);

    localparam int AW    = 2 * DATA_WIDTH;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0]  dvd_reg, dvd_next;
    logic [DATA_WIDTH-1:0]  rem_reg, rem_next;
    logic signed [AW-1:0]   acc_x_reg, acc_x_next;
    logic signed [AW-1:0]   acc_y_reg, acc_y_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DATA_WIDTH:0]    trial;
    logic [DATA_WIDTH:0]    diff;
    logic                   qbit;

    always_comb begin
        trial      = {rem_reg, dvd_reg[DATA_WIDTH-1]};
        diff       = trial - {1'b0, divisor};
        qbit       = ~diff[DATA_WIDTH];
        rem_next   = qbit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        dvd_next   = {dvd_reg[DATA_WIDTH-2:0], 1'b0};
        acc_x_next = (acc_x_reg <<< 1) + (qbit ? AW'(mul_x) : AW'(0));
        acc_y_next = (acc_y_reg <<< 1) + (qbit ? AW'(mul_y) : AW'(0));
        cnt_next   = cnt_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ctl.start) begin
            cnt_reg <= '0;
        end else if (ctl.step) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            dvd_reg   <= dividend;
            rem_reg   <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end else if (ctl.step) begin
            dvd_reg   <= dvd_next;
            rem_reg   <= rem_next;
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
        end
    end

    assign rem   = rem_reg;
    assign acc_x = acc_x_reg;
    assign acc_y = acc_y_reg;
    assign last  = (cnt_reg == CNT_W'(DATA_WIDTH - 1));

endmodule

[design/extended_gcd_diophantine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_diophantine_core
// Run time depends on n, the number of Euclid
// quotient steps (up to about 46 at 32 bits); a = b = 0 skips the divider.
// Each quotient step and the final c/g scaling take one pass of the shared divider.
// One transaction in flight: s_tready rises together with m_tvalid, when the result register loads.
// Synchronous active-low reset clears the sequencer and m_tvalid.
// ----------------------------------------------------------------------------
module extended_gcd_diophantine_core
    import egcd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // coeff_a, coeff_b, target_c
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // gcd_out, bezout_x, bezout_y, solvable, solution_x, solution_y, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int CW = DATA_WIDTH + 2;
    localparam int AW = 2 * DATA_WIDTH;

    state_t state_reg, state_next;

    logic [DATA_WIDTH-1:0]  r0_reg, r1_reg;
    logic signed [CW-1:0]   px_reg, py_reg, qx_reg, qy_reg;
    logic [DATA_WIDTH-1:0]  c_mag_reg;
    logic                   neg_a_reg, neg_b_reg, neg_c_reg, c_zero_reg;
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    logic [DATA_WIDTH-1:0]  a_w, b_w, c_w;
    logic [DATA_WIDTH-1:0]  a_mag, b_mag, c_mag;

    unit_ctl_t              ctl;
    logic [DATA_WIDTH-1:0]  u_dividend, u_divisor, u_rem;
    logic signed [CW-1:0]   u_mul_x, u_mul_y;
    logic signed [AW-1:0]   u_acc_x, u_acc_y;
    logic                   u_last;

    logic                   out_free, load_out;
    logic                   g_zero, ok, use_sol;
    logic signed [SOL_W-1:0] px_ext, py_ext, sx_mag, sy_mag, sol_x, sol_y;
    logic [OUT_FIELDS_W-1:0] out_fields;

    // input decode
    always_comb begin
        a_w   = s_tdata[0 +: DATA_WIDTH];
        b_w   = s_tdata[FIELD_W +: DATA_WIDTH];
        c_w   = s_tdata[2 * FIELD_W +: DATA_WIDTH];
        a_mag = a_w[DATA_WIDTH-1] ? (~a_w + 1'b1) : a_w;
        b_mag = b_w[DATA_WIDTH-1] ? (~b_w + 1'b1) : b_w;
        c_mag = c_w[DATA_WIDTH-1] ? (~c_w + 1'b1) : c_w;
    end

    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (r1_reg != '0) state_next = ST_DIV;
                else if (r0_reg != '0) state_next = ST_SOLVE;
                else state_next = ST_DONE;
            end
            ST_DIV: begin
                if (u_last) state_next = ST_UPD;
            end
            ST_UPD: begin
                state_next = ST_CHECK;
            end
            ST_SOLVE: begin
                if (u_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        ctl.start = 1'b0;
        ctl.step  = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_CHECK: ctl.start = (r1_reg != '0) || (r0_reg != '0);
            ST_DIV:   ctl.step  = 1'b1;
            ST_UPD:   ;
            ST_SOLVE: ctl.step  = 1'b1;
            ST_DONE:  load_out  = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // shared divider operand selection
    always_comb begin
        u_dividend = (r1_reg != '0) ? r0_reg : c_mag_reg;
        u_divisor  = (state_reg == ST_SOLVE) ? r0_reg : r1_reg;
        u_mul_x    = (state_reg == ST_SOLVE) ? px_reg : qx_reg;
        u_mul_y    = (state_reg == ST_SOLVE) ? py_reg : qy_reg;
    end

    egcd_divmac #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_divmac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .dividend (u_dividend),
        .divisor  (u_divisor),
        .mul_x    (u_mul_x),
        .mul_y    (u_mul_y),
        .rem      (u_rem),
        .acc_x    (u_acc_x),
        .acc_y    (u_acc_y),
        .last     (u_last)
    );

    // euclid state
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            r0_reg     <= a_mag;
            r1_reg     <= b_mag;
            px_reg     <= CW'(1);
            py_reg     <= CW'(0);
            qx_reg     <= CW'(0);
            qy_reg     <= CW'(1);
            c_mag_reg  <= c_mag;
            neg_a_reg  <= a_w[DATA_WIDTH-1];
            neg_b_reg  <= b_w[DATA_WIDTH-1];
            neg_c_reg  <= c_w[DATA_WIDTH-1];
            c_zero_reg <= (c_w == '0);
        end else if (state_reg == ST_UPD) begin
            r0_reg <= r1_reg;
            r1_reg <= u_rem;
            px_reg <= qx_reg;
            py_reg <= qy_reg;
            qx_reg <= px_reg - CW'(u_acc_x);
            qy_reg <= py_reg - CW'(u_acc_y);
        end
    end

    // result assembly
    always_comb begin
        g_zero  = (r0_reg == '0);
        ok      = g_zero ? c_zero_reg : (u_rem == '0);
        use_sol = ok && !g_zero;
        px_ext  = SOL_W'(px_reg);
        py_ext  = SOL_W'(py_reg);
        sx_mag  = SOL_W'(u_acc_x);
        sy_mag  = SOL_W'(u_acc_y);
        sol_x   = '0;
        sol_y   = '0;
        if (use_sol) begin
            sol_x = (neg_c_reg ^ neg_a_reg) ? -sx_mag : sx_mag;
            sol_y = (neg_c_reg ^ neg_b_reg) ? -sy_mag : sy_mag;
        end
        out_fields = {sol_y, sol_x, ok, py_ext[COEF_W-1:0], px_ext[COEF_W-1:0],
                      FIELD_W'(r0_reg)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= OUT_TDATA_W'(out_fields);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[design/egcd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_checker
// Port-level checks for the extended gcd core, bound to the top level.
// ----------------------------------------------------------------------------
module egcd_checker
    import egcd_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // one transaction in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // no solution values without solvable
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[OK_BIT] |->
            m_tdata[SX_LSB +: SOL_W] == '0 && m_tdata[SY_LSB +: SOL_W] == '0)
        else $error("solution nonzero when not solvable");

    // zero gcd only for both inputs zero: x0 = 1, y0 = 0, solution (0,0); only solution_x is checked
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[GCD_LSB +: FIELD_W] == '0 |->
            m_tdata[BX_LSB +: COEF_W] == COEF_W'(1) &&
            m_tdata[BY_LSB +: COEF_W] == '0 &&
            m_tdata[SX_LSB +: SOL_W] == '0)
        else $error("bad result for zero gcd");

endmodule

bind extended_gcd_diophantine_core egcd_checker u_egcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
